// File: rtl/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg - shared definitions for the generator command parser
// Field widths, register indexes, character codes and the classified
// byte token that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package gcp_pkg;

	localparam int BYTE_W      = 8;
	localparam int UVAL_W      = 20;
	localparam int SVAL_W      = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 21;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_MAX  = 3'd5;

	// Register reset values
	localparam logic [UVAL_W-1:0] FREQ_MIN_RST = 20'd20;
	localparam logic [UVAL_W-1:0] FREQ_MAX_RST = 20'd2000;
	localparam logic [UVAL_W-1:0] AMP_MIN_RST  = 20'd0;
	localparam logic [UVAL_W-1:0] AMP_MAX_RST  = 20'd10000;
	localparam logic [SVAL_W-1:0] OFF_MIN_RST  = 21'h1FEC78; // -5000
	localparam logic [SVAL_W-1:0] OFF_MAX_RST  = 21'd5000;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_SINE     = 8'h53; // 'S'
	localparam logic [BYTE_W-1:0] CH_TRIANGLE = 8'h54; // 'T'
	localparam logic [BYTE_W-1:0] CH_SAWTOOTH = 8'h44; // 'D'
	localparam logic [BYTE_W-1:0] CH_SQUARE   = 8'h43; // 'C'
	localparam logic [BYTE_W-1:0] CH_ONE      = 8'h31; // '1'
	localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30; // '0'
	localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39; // '9'
	localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B; // '+'
	localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D; // '-'
	localparam logic [BYTE_W-1:0] FIELD_CHAR_MAX = 8'h39;

	typedef enum logic [1:0] {
		SHAPE_SINE     = 2'd0,
		SHAPE_TRIANGLE = 2'd1,
		SHAPE_SAWTOOTH = 2'd2,
		SHAPE_SQUARE   = 2'd3
	} shape_t;

	// One received byte after classification
	typedef struct packed {
		logic       start;
		logic       digit_ok;
		logic [3:0] digit;
		logic       sign_ok;
		logic       minus;
		logic       above_max;
		logic       shape_ok;
		shape_t     shape;
		logic       save_one;
	} token_t;

endpackage

// File: rtl/gcp_if.sv
// ----------------------------------------------------------------------------
// gcp_if - channel interfaces of the generator command parser
// Command byte channel, result channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gcp_cmd_if import gcp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              msg_start;

	modport source (output valid, rx_byte, msg_start, input ready);
	modport sink   (input valid, rx_byte, msg_start, output ready);
endinterface

interface gcp_res_if import gcp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              msg_ok;
	logic [1:0]        wave_shape;
	logic [UVAL_W-1:0] frequency;
	logic [UVAL_W-1:0] amplitude;
	logic [SVAL_W-1:0] offset;
	logic              save_request;

	modport source (output valid, msg_ok, wave_shape, frequency, amplitude, offset,
		save_request, input ready);
	modport sink   (input valid, msg_ok, wave_shape, frequency, amplitude, offset,
		save_request, output ready);
endinterface

interface gcp_cfg_if import gcp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gcp_front.sv
// ----------------------------------------------------------------------------
// gcp_front - byte classifier
// Accepts command bytes while the queue has room and turns each one into
// a token that flags digits, signs, shape letters and field terminators.
// ----------------------------------------------------------------------------
module gcp_front import gcp_pkg::*; (
	gcp_cmd_if.sink cmd,
	input  logic    queue_full,
	output logic    push,
	output token_t  push_token
);

	logic [BYTE_W-1:0] b;

	assign b          = cmd.rx_byte;
	assign cmd.ready  = !queue_full;
	assign push       = cmd.valid && !queue_full;

	always_comb begin
		push_token.start     = cmd.msg_start;
		push_token.digit_ok  = (b >= CH_ZERO) && (b <= CH_NINE);
		push_token.digit     = b[3:0];
		push_token.sign_ok   = (b == CH_PLUS) || (b == CH_MINUS);
		push_token.minus     = (b == CH_MINUS);
		push_token.above_max = (b > FIELD_CHAR_MAX);
		push_token.save_one  = (b == CH_ONE);
		push_token.shape_ok  = 1'b1;
		case (b)
			CH_SINE:     push_token.shape = SHAPE_SINE;
			CH_TRIANGLE: push_token.shape = SHAPE_TRIANGLE;
			CH_SAWTOOTH: push_token.shape = SHAPE_SAWTOOTH;
			CH_SQUARE:   push_token.shape = SHAPE_SQUARE;
			default: begin
				push_token.shape    = SHAPE_SINE;
				push_token.shape_ok = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/gcp_queue.sv
// ----------------------------------------------------------------------------
// gcp_queue - token queue
// Small register queue between the classifier and the parser so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module gcp_queue import gcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_token,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output token_t head_token
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_token = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_token;
	end

endmodule

// File: rtl/gcp_back.sv
// ----------------------------------------------------------------------------
// gcp_back - message parser and parameter store
// Walks the message state for each token, accumulates decimal fields,
// clamps them into the stored parameters through a store stage and presents one
// result per message through an output register.
// ----------------------------------------------------------------------------
module gcp_back import gcp_pkg::*; #(
	parameter int FIELD_BYTES = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	gcp_cfg_if.sink   cfg,
	input  logic      head_valid,
	input  token_t    head_token,
	output logic      pop,
	gcp_res_if.source res
);

	localparam int LEN_W = $clog2(FIELD_BYTES + 1);
	localparam int POS_W = 3;
	localparam int ACC_W = UVAL_W + 4;
	localparam int CMP_W = SVAL_W + 1;
	localparam logic [POS_W-1:0] POS_SHAPE     = 3'd3;
	localparam logic [POS_W-1:0] POS_HEAD_LAST = 3'd5;
	localparam logic [POS_W-1:0] POS_SKIP_ONE  = 3'd1;
	localparam logic [POS_W-1:0] POS_SKIP_TWO  = 3'd2;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_HEAD = 6'b000010,
		PH_FREQ = 6'b000100,
		PH_AMP  = 6'b001000,
		PH_OFF  = 6'b010000,
		PH_SAVE = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		TGT_FREQ = 3'b001,
		TGT_AMP  = 3'b010,
		TGT_OFF  = 3'b100
	} target_t;

	// Configuration registers
	logic [UVAL_W-1:0] freq_min_q, freq_max_q, amp_min_q, amp_max_q;
	logic [SVAL_W-1:0] off_min_q, off_max_q;

	// Parser state
	phase_t            phase_q, ph, phase_d;
	logic [POS_W-1:0]  pos_q, pos, pos_d;
	logic [LEN_W-1:0]  len_q, len, len_d;
	logic              ended_q, ended, ended_d;
	logic              neg_q, neg, neg_d;
	logic [UVAL_W-1:0] acc_q, acc, acc_d;
	shape_t            shape_q, shape_d;
	logic [ACC_W-1:0]  acc_x10;

	logic              emit, emit_ok, emit_save, store;
	target_t           tgt;

	// Store stage
	logic              st_valid_s1;
	target_t           st_tgt_s1;
	logic              st_neg_s1;
	logic [UVAL_W-1:0] st_acc_s1;

	logic signed [CMP_W-1:0] st_mag, st_val, st_lo, st_hi, st_clamped;

	// Stored parameters
	logic [UVAL_W-1:0] freq_q, amp_q, freq_now, amp_now;
	logic [SVAL_W-1:0] off_q, off_now;

	// Output register
	logic              res_valid_q, res_ok_q, res_save_q, out_free;
	shape_t            res_shape_q;
	logic [UVAL_W-1:0] res_freq_q, res_amp_q;
	logic [SVAL_W-1:0] res_off_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_min_q <= FREQ_MIN_RST;
			freq_max_q <= FREQ_MAX_RST;
			amp_min_q  <= AMP_MIN_RST;
			amp_max_q  <= AMP_MAX_RST;
			off_min_q  <= OFF_MIN_RST;
			off_max_q  <= OFF_MAX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FREQ_MIN: freq_min_q <= cfg.data[UVAL_W-1:0];
				CFG_FREQ_MAX: freq_max_q <= cfg.data[UVAL_W-1:0];
				CFG_AMP_MIN:  amp_min_q  <= cfg.data[UVAL_W-1:0];
				CFG_AMP_MAX:  amp_max_q  <= cfg.data[UVAL_W-1:0];
				CFG_OFF_MIN:  off_min_q  <= cfg.data[SVAL_W-1:0];
				CFG_OFF_MAX:  off_max_q  <= cfg.data[SVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// A start flag abandons whatever message was in progress.
		ph    = phase_q;
		pos   = pos_q;
		len   = len_q;
		ended = ended_q;
		neg   = neg_q;
		acc   = acc_q;
		if (head_token.start) begin
			ph    = PH_HEAD;
			pos   = '0;
			len   = '0;
			ended = 1'b0;
			neg   = 1'b0;
			acc   = '0;
		end

		acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {20'd0, head_token.digit};

		phase_d   = ph;
		pos_d     = pos;
		len_d     = len;
		ended_d   = ended;
		neg_d     = neg;
		acc_d     = acc;
		shape_d   = shape_q;
		emit      = 1'b0;
		emit_ok   = 1'b0;
		emit_save = 1'b0;
		store     = 1'b0;
		tgt       = TGT_FREQ;

		case (ph)
			PH_HEAD: begin
				if (pos == POS_SHAPE && !head_token.shape_ok) begin
					emit = 1'b1;
				end else begin
					if (pos == POS_SHAPE)
						shape_d = head_token.shape;
					if (pos >= POS_HEAD_LAST) begin
						phase_d = PH_FREQ;
						pos_d   = '0;
					end else begin
						pos_d = pos + POS_W'(1);
					end
				end
			end
			PH_FREQ, PH_AMP, PH_OFF: begin
				tgt = (ph == PH_FREQ) ? TGT_FREQ : ((ph == PH_AMP) ? TGT_AMP : TGT_OFF);
				if (pos != '0) begin
					// Counting down the bytes that follow a field.
					pos_d = pos - POS_W'(1);
					if (pos == POS_SKIP_ONE) begin
						phase_d = (ph == PH_FREQ) ? PH_AMP : ((ph == PH_AMP) ? PH_OFF : PH_SAVE);
						len_d   = '0;
						ended_d = 1'b0;
						neg_d   = 1'b0;
						acc_d   = '0;
					end
				end else if (head_token.above_max && !(ph == PH_OFF && len == '0)) begin
					// The terminator itself is the first of the two skipped bytes.
					if (len == '0) begin
						emit = 1'b1;
					end else begin
						store = 1'b1;
						pos_d = POS_SKIP_ONE;
					end
				end else begin
					if (len == '0 && head_token.sign_ok) begin
						neg_d = head_token.minus;
					end else if (!ended && head_token.digit_ok) begin
						acc_d = (acc_x10[ACC_W-1:UVAL_W] != '0) ? {UVAL_W{1'b1}}
							: acc_x10[UVAL_W-1:0];
					end else begin
						ended_d = 1'b1;
					end
					len_d = len + LEN_W'(1);
					if (len_d >= LEN_W'(FIELD_BYTES)) begin
						store = 1'b1;
						pos_d = POS_SKIP_TWO;
					end
				end
			end
			PH_SAVE: begin
				emit      = 1'b1;
				emit_ok   = 1'b1;
				emit_save = head_token.save_one;
			end
			default: phase_d = PH_IDLE;
		endcase

		if (emit) begin
			phase_d = PH_IDLE;
			pos_d   = '0;
			len_d   = '0;
			ended_d = 1'b0;
			neg_d   = 1'b0;
			acc_d   = '0;
		end
	end

	// A token that produces a result waits for the output register.
	assign out_free = !res_valid_q || res.ready;
	assign pop      = head_valid && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			len_q       <= '0;
			ended_q     <= 1'b0;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			shape_q     <= SHAPE_SINE;
			st_valid_s1 <= 1'b0;
		end else begin
			st_valid_s1 <= pop && store;
			if (pop) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				len_q   <= len_d;
				ended_q <= ended_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				shape_q <= shape_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && store) begin
			st_tgt_s1 <= tgt;
			st_neg_s1 <= neg_d;
			st_acc_s1 <= acc_d;
		end
	end

	// Clamp the completed field against its limits.
	always_comb begin
		st_mag = $signed({2'b00, st_acc_s1});
		st_val = st_neg_s1 ? (CMP_W'(0) - st_mag) : st_mag;
		case (st_tgt_s1)
			TGT_FREQ: begin
				st_lo = $signed({2'b00, freq_min_q});
				st_hi = $signed({2'b00, freq_max_q});
			end
			TGT_AMP: begin
				st_lo = $signed({2'b00, amp_min_q});
				st_hi = $signed({2'b00, amp_max_q});
			end
			default: begin
				st_lo = $signed({off_min_q[SVAL_W-1], off_min_q});
				st_hi = $signed({off_max_q[SVAL_W-1], off_max_q});
			end
		endcase
		if (st_val > st_hi)
			st_clamped = st_hi;
		else if (st_val < st_lo)
			st_clamped = st_lo;
		else
			st_clamped = st_val;
	end

	// The result sees a field committed in the same cycle.
	assign freq_now = (st_valid_s1 && st_tgt_s1 == TGT_FREQ) ? st_clamped[UVAL_W-1:0] : freq_q;
	assign amp_now  = (st_valid_s1 && st_tgt_s1 == TGT_AMP)  ? st_clamped[UVAL_W-1:0] : amp_q;
	assign off_now  = (st_valid_s1 && st_tgt_s1 == TGT_OFF)  ? st_clamped[SVAL_W-1:0] : off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= '0;
			amp_q       <= '0;
			off_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			freq_q <= freq_now;
			amp_q  <= amp_now;
			off_q  <= off_now;
			if (pop && emit)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_ok_q    <= emit_ok;
			res_shape_q <= shape_q;
			res_freq_q  <= freq_now;
			res_amp_q   <= amp_now;
			res_off_q   <= off_now;
			res_save_q  <= emit_save;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.msg_ok       = res_ok_q;
	assign res.wave_shape   = res_shape_q;
	assign res.frequency    = res_freq_q;
	assign res.amplitude    = res_amp_q;
	assign res.offset       = res_off_q;
	assign res.save_request = res_save_q;

endmodule

// File: rtl/generator_command_parser.sv
// ----------------------------------------------------------------------------
// generator_command_parser - signal generator command message parser
// Parses shape, frequency, amplitude, offset and save flag from a byte
// stream and reports one result per message.
// ----------------------------------------------------------------------------
// The block takes one command byte per clock cycle for as long as results are
// taken. A byte is classified on entry and queued in a two-entry token queue;
// the parser pops one token per cycle unless a token waits, and the result of a
// message is loaded into the output register as its last byte leaves the queue.
// Only a byte that ends a message waits while an earlier result sits untaken in
// the output register, and the queue then absorbs one more byte before the
// command channel stalls. A completed field is captured in the store stage as
// its last byte leaves the queue, then clamped and committed to the parameters.
// Configuration writes are accepted every cycle and should only be made while
// no message is in progress.
module generator_command_parser import gcp_pkg::*; #(
	parameter int FIELD_BYTES = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	gcp_cmd_if.sink   cmd,
	gcp_res_if.source res,
	gcp_cfg_if.sink   cfg
);

	logic   push, queue_full, pop, head_valid;
	token_t push_token, head_token;

	gcp_front u_front (
		.cmd        (cmd),
		.queue_full (queue_full),
		.push       (push),
		.push_token (push_token)
	);

	gcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_token (head_token)
	);

	gcp_back #(
		.FIELD_BYTES (FIELD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_token (head_token),
		.pop        (pop),
		.res        (res)
	);

endmodule

// File: rtl/gcp_checker.sv
// ----------------------------------------------------------------------------
// gcp_checker - port-level checks for the generator command parser
// Watches the command and result channels and flags behaviour the parser
// must never show.
// ----------------------------------------------------------------------------
module gcp_checker import gcp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic              res_msg_ok,
	input logic              res_save_request,
	input logic [UVAL_W-1:0] res_frequency,
	input logic [SVAL_W-1:0] res_offset
);

	// A held result keeps its ok flag, frequency and offset until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_msg_ok)
			&& $stable(res_frequency) && $stable(res_offset))
		else $error("result changed while stalled");

	// A message that ended in an error never requests a save.
	a_err_no_save: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_msg_ok |-> !res_save_request)
		else $error("error result carries a save request");

	// The queue can only fill up on a request just accepted.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd_ready) |-> $past(cmd_valid && cmd_ready))
		else $error("command ready dropped without a request");

endmodule

bind generator_command_parser gcp_checker u_gcp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_msg_ok       (res.msg_ok),
	.res_save_request (res.save_request),
	.res_frequency    (res.frequency),
	.res_offset       (res.offset)
);
